[hdl/kmp_pkg.sv]
// Shared types and constants for the KMP stream matcher.
package kmp_pkg;

	// Width of the reported start position
	localparam int MATCH_BITS = 20;

	// Values of the command input
	localparam logic CMD_PATTERN = 1'b0;
	localparam logic CMD_TEXT    = 1'b1;

	// Work classes handed from the front end to the engine
	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0, // append a pattern token
		OP_RESTART = 2'd1, // first token of a new pattern, restarts length, build, match and position
		OP_SEARCH  = 2'd2, // text token against a ready pattern
		OP_FLUSH   = 2'd3  // last text token with no pattern: clear position and match state
	} op_t;

	typedef struct packed {
		op_t  op;
		logic last;
	} cmd_t;

endpackage

[hdl/kmp_front.sv]
// Front end: accepts input words, classifies them and queues them for the engine.
module kmp_front #(
	parameter int SYMBOL_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic                   command,
	input  logic [SYMBOL_BITS-1:0] symbol,
	input  logic                   last,
	output logic                   cmd_valid,
	output kmp_pkg::cmd_t          cmd,
	output logic [SYMBOL_BITS-1:0] cmd_symbol,
	input  logic                   cmd_pop
);
	import kmp_pkg::*;

	localparam int QDEPTH = 2;

	logic                   ready_q;
	cmd_t                   cmd_mem [QDEPTH];
	logic [SYMBOL_BITS-1:0] sym_mem [QDEPTH];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             count_q;

	logic accept;
	logic keep;
	logic wr_en;
	cmd_t cmd_in;

	assign full   = (count_q == 2'(QDEPTH));
	assign accept = push && !full;

	// Classify against the pattern state left by the words ahead in the queue
	always_comb begin
		cmd_in.last = last;
		if (command == CMD_PATTERN) begin
			cmd_in.op = ready_q ? OP_RESTART : OP_LOAD;
		end else begin
			cmd_in.op = ready_q ? OP_SEARCH : OP_FLUSH;
		end
	end

	// Text with no pattern only matters when it ends the text
	assign keep  = (command == CMD_PATTERN) || ready_q || last;
	assign wr_en = accept && keep;

	// Pattern becomes ready on its last token, a new pattern token drops it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else if (accept && command == CMD_PATTERN) begin
			ready_q <= last;
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cmd_mem[wr_ptr_q] <= cmd_in;
			sym_mem[wr_ptr_q] <= symbol;
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(wr_en) - 2'(cmd_pop);
		end
	end

	assign cmd_valid  = (count_q != 2'd0);
	assign cmd        = cmd_mem[rd_ptr_q];
	assign cmd_symbol = sym_mem[rd_ptr_q];

endmodule

[hdl/kmp_engine.sv]
// Back end: pattern store, failure table build and the KMP match walk.
module kmp_engine #(
	parameter int PATTERN_DEPTH = 16,
	parameter int SYMBOL_BITS   = 16,
	parameter int POSITION_BITS = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	input  kmp_pkg::cmd_t                    cmd,
	input  logic [SYMBOL_BITS-1:0]           cmd_symbol,
	output logic                             cmd_pop,
	input  logic                             res_full,
	output logic                             res_push,
	output logic [kmp_pkg::MATCH_BITS-1:0]   res_start
);
	import kmp_pkg::*;

	localparam int IW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int LW = $clog2(PATTERN_DEPTH + 1);
	localparam int FW = IW + 1; // failure links carry a sign bit for minus one
	localparam logic [LW-1:0] LEN_FULL = LW'(PATTERN_DEPTH);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_STEP = 1'b1;

	// Control state
	logic                     state_q, state_d;
	logic [LW-1:0]            len_q, len_d;
	logic [IW-1:0]            build_q, build_d;
	logic [IW-1:0]            border_q, border_d;
	logic [IW-1:0]            match_q, match_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;

	// Word under work
	logic [SYMBOL_BITS-1:0]   sym_q, sym_d;
	logic                     last_q, last_d;
	logic                     text_q, text_d;
	logic                     first_q, first_d;
	logic [FW-1:0]            j_q, j_d;
	logic [IW-1:0]            i_q, i_d;

	// Memories
	logic [SYMBOL_BITS-1:0]   store_mem [PATTERN_DEPTH];
	logic [FW-1:0]            fail_mem  [PATTERN_DEPTH];
	logic [SYMBOL_BITS-1:0]   store_rd_q;
	logic [FW-1:0]            fail_rd_q;

	logic [IW-1:0]            rd_addr;
	logic                     store_we;
	logic [IW-1:0]            store_waddr;
	logic                     fail_we;
	logic [FW-1:0]            fail_wdata;

	logic                     eq;
	logic [FW-1:0]            f;
	logic                     f_neg;
	logic [LW-1:0]            jn;
	logic                     hit;
	logic [IW-1:0]            step_val;
	logic [POSITION_BITS-1:0] start;

	// One table step: compare stored token, follow link on mismatch
	assign eq       = (store_rd_q == sym_q);
	assign f        = (j_q == '0) ? '1 : fail_rd_q; // entry zero links to minus one
	assign f_neg    = f[FW-1];
	assign jn       = LW'(j_q[IW-1:0]) + LW'(1);
	assign hit      = eq && (jn == len_q);
	assign step_val = eq ? jn[IW-1:0] : '0;
	assign start    = pos_q - POSITION_BITS'(len_q - LW'(1));
	assign res_start = MATCH_BITS'(start);

	always_comb begin
		state_d     = state_q;
		len_d       = len_q;
		build_d     = build_q;
		border_d    = border_q;
		match_d     = match_q;
		pos_d       = pos_q;
		sym_d       = sym_q;
		last_d      = last_q;
		text_d      = text_q;
		first_d     = first_q;
		j_d         = j_q;
		i_d         = i_q;
		cmd_pop     = 1'b0;
		res_push    = 1'b0;
		rd_addr     = match_q;
		store_we    = 1'b0;
		store_waddr = len_q[IW-1:0];
		fail_we     = 1'b0;
		fail_wdata  = eq ? f : j_q;

		unique case (state_q)
			ST_IDLE: begin
				// a search only starts when its result has room
				if (cmd_valid && (cmd.op != OP_SEARCH || !res_full)) begin
					cmd_pop = 1'b1;
					sym_d   = cmd_symbol;
					last_d  = cmd.last;
					unique case (cmd.op)
						OP_RESTART: begin
							store_we    = 1'b1;
							store_waddr = '0;
							len_d       = LW'(1);
							build_d     = '0;
							match_d     = '0;
							pos_d       = '0;
							if (cmd.last) border_d = '0;
						end
						OP_LOAD: begin
							if (len_q != LEN_FULL) begin
								store_we = 1'b1;
								len_d    = len_q + LW'(1);
							end
							if (len_q != LEN_FULL && len_q != '0) begin
								// walk the links from the current border
								rd_addr = build_q;
								j_d     = FW'(build_q);
								i_d     = len_q[IW-1:0];
								first_d = 1'b1;
								text_d  = 1'b0;
								state_d = ST_STEP;
							end else if (cmd.last) begin
								border_d = build_q;
							end
						end
						OP_SEARCH: begin
							rd_addr = match_q;
							j_d     = FW'(match_q);
							text_d  = 1'b1;
							state_d = ST_STEP;
						end
						OP_FLUSH: begin
							pos_d   = '0;
							match_d = '0;
						end
						default: ;
					endcase
				end
			end
			ST_STEP: begin
				// new pattern entry's link comes from the first compare
				if (!text_q && first_q) fail_we = 1'b1;
				first_d = 1'b0;
				if (eq || f_neg) begin
					state_d = ST_IDLE;
					if (text_q) begin
						res_push = hit;
						match_d  = hit ? border_q : step_val;
						if (last_q) begin
							pos_d   = '0;
							match_d = '0;
						end else if (pos_q != '1) begin
							pos_d = pos_q + POSITION_BITS'(1);
						end
					end else begin
						build_d = step_val;
						if (last_q) border_d = step_val;
					end
				end else begin
					j_d     = f;
					rd_addr = f[IW-1:0];
				end
			end
			default: ;
		endcase
	end

	// Pattern store and failure table, registered reads
	always_ff @(posedge clk) begin
		if (store_we) store_mem[store_waddr] <= cmd_symbol;
		if (fail_we) fail_mem[i_q] <= fail_wdata;
		store_rd_q <= store_mem[rd_addr];
		fail_rd_q  <= fail_mem[rd_addr];
	end

	// Word under work
	always_ff @(posedge clk) begin
		sym_q   <= sym_d;
		last_q  <= last_d;
		text_q  <= text_d;
		first_q <= first_d;
		j_q     <= j_d;
		i_q     <= i_d;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			len_q    <= '0;
			build_q  <= '0;
			border_q <= '0;
			match_q  <= '0;
			pos_q    <= '0;
		end else begin
			state_q  <= state_d;
			len_q    <= len_d;
			build_q  <= build_d;
			border_q <= border_d;
			match_q  <= match_d;
			pos_q    <= pos_d;
		end
	end

endmodule

[hdl/kmp_out_queue.sv]
// Two-word result queue between the engine and the result port.
module kmp_out_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           res_push,
	input  logic [kmp_pkg::MATCH_BITS-1:0] res_start,
	output logic                           res_full,
	output logic                           empty,
	input  logic                           pop,
	output logic [kmp_pkg::MATCH_BITS-1:0] match_start
);
	import kmp_pkg::*;

	localparam int QDEPTH = 2;

	logic [MATCH_BITS-1:0] data_mem [QDEPTH];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;
	logic                  rd_en;

	assign res_full    = (count_q == 2'(QDEPTH));
	assign empty       = (count_q == 2'd0);
	assign rd_en       = pop && !empty;
	assign match_start = data_mem[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (res_push) data_mem[wr_ptr_q] <= res_start;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (res_push) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(res_push) - 2'(rd_en);
		end
	end

endmodule

[hdl/kmp_stream_matcher.sv]
// Top level of the KMP stream matcher: front end, engine and result queue.
// Pattern words (command 0) are loaded one by one and build the failure table as they
// arrive; the word with last set closes the pattern, and a later pattern word starts a
// new one and clears the search. Text words (command 1) are then matched, and each
// complete occurrence, overlapping ones included, yields one result word holding the
// text position of its first token. A text word with last set ends the text and
// restarts positions at zero. Timing: a text word, or a pattern word past the first,
// passes from the engine's idle state into its step state, which follows one
// failure link per cycle through the registered read port of the pattern and failure
// memories until a compare matches or the links run out. The first pattern word,
// pattern words past PATTERN_DEPTH and a text word with last set but no pattern are
// handled in the idle state alone; other text words with no pattern are dropped by
// the front end and never reach the engine. A text word waits in the engine's idle
// state while the result queue is full. A two-word queue on each side keeps input
// and output decoupled from the engine. No clearing pass is needed after reset.
module kmp_stream_matcher #(
	parameter int PATTERN_DEPTH = 16,
	parameter int SYMBOL_BITS   = 16,
	parameter int POSITION_BITS = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           command,
	input  logic [SYMBOL_BITS-1:0]         symbol,
	input  logic                           last,
	output logic                           empty,
	input  logic                           pop,
	output logic [kmp_pkg::MATCH_BITS-1:0] match_start
);
	import kmp_pkg::*;

	logic                   cmd_valid;
	cmd_t                   cmd;
	logic [SYMBOL_BITS-1:0] cmd_symbol;
	logic                   cmd_pop;
	logic                   res_full;
	logic                   res_push;
	logic [MATCH_BITS-1:0]  res_start;

	kmp_front #(
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.symbol     (symbol),
		.last       (last),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_symbol (cmd_symbol),
		.cmd_pop    (cmd_pop)
	);

	kmp_engine #(
		.PATTERN_DEPTH (PATTERN_DEPTH),
		.SYMBOL_BITS   (SYMBOL_BITS),
		.POSITION_BITS (POSITION_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_symbol (cmd_symbol),
		.cmd_pop    (cmd_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_start  (res_start)
	);

	kmp_out_queue u_out_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_push    (res_push),
		.res_start   (res_start),
		.res_full    (res_full),
		.empty       (empty),
		.pop         (pop),
		.match_start (match_start)
	);

	// Engine only reserves result room it actually has
	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written into a full queue");

	// Engine never takes a word the front end does not hold
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("engine popped an empty command queue");

	// After a produced result the output queue is not empty on the next cycle
	a_result_visible: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> !empty)
		else $error("result lost between engine and output");

endmodule
